FILE: hdl/moving_mean_and_std_dev_macros.svh
// Assertion macros for the moving mean and deviation block.
// Taken in by the top level; expects i_clk and i_rst_n in scope.
`ifndef MOVING_MEAN_AND_STD_DEV_MACROS_SVH
`define MOVING_MEAN_AND_STD_DEV_MACROS_SVH

// same-cycle implication
`define MMSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mmsd_pkg.sv
// Shared types and constants for the moving mean and deviation block.
// No dependencies.
package mmsd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int MV_W     = 14;
    localparam int MEAN_W   = 16;
    localparam int SIG_W    = 16;
    localparam int CNT_W    = 5;

    localparam logic [SAMPLE_W-1:0] ADC_FULL_CODE = 12'd4095;
    localparam logic [MV_W-1:0]     FS_MV_RESET   = 14'd1250;
    localparam logic [SIG_W-1:0]    SIG_MAX       = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_SQO,
        ST_SQX,
        ST_CSQ,
        ST_SS,
        ST_DEN,
        ST_DV1,
        ST_SQRT,
        ST_DV2,
        ST_SFS,
        ST_FC,
        ST_DV3,
        ST_OUT
    } t_state;

endpackage

FILE: hdl/moving_mean_and_std_dev.sv
// Moving mean and sample standard deviation over a ring of WINDOW samples.
// Built on serial multiply, divide and square-root units, started one at a time.
// One transaction at a time: the next is taken only after the result is parked.
// Synchronous active-low reset clears sums and counts and sets full scale to 1250.
// Uses mmsd_pkg, mmsd_mul, mmsd_div, mmsd_sqrt and the assertion macro header.
`include "moving_mean_and_std_dev_macros.svh"
module moving_mean_and_std_dev #(
    parameter int WINDOW = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [mmsd_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [mmsd_pkg::MEAN_W-1:0]    o_mean_q4,
    output logic [mmsd_pkg::SIG_W-1:0]     o_sigma_q4,
    output logic [mmsd_pkg::MV_W-1:0]      o_expected_mv,
    output logic [mmsd_pkg::CNT_W-1:0]     o_fill_count,
    input  logic                           i_cfg_we,
    input  logic [mmsd_pkg::MV_W-1:0]      i_cfg_wdata
);
    import mmsd_pkg::*;

    localparam int CW  = $clog2(WINDOW + 1);
    localparam int LW  = $clog2(WINDOW);
    localparam int SW  = SAMPLE_W + LW;
    localparam int QSW = 2 * SAMPLE_W + LW;
    localparam int DW  = CW + QSW;
    localparam int MA  = QSW;
    localparam int MB  = (SW > MV_W) ? SW : MV_W;
    localparam int PW  = MA + MB;
    localparam int NW  = DW + 10;
    localparam int VW  = SAMPLE_W + CW;
    localparam int RW  = (NW + 1) / 2;

    logic [SAMPLE_W-1:0] mem [WINDOW];

    t_state              r_state, n_state;
    logic                r_run, n_run;
    logic [SAMPLE_W-1:0] r_x;
    logic [SAMPLE_W-1:0] r_rd;
    logic [SAMPLE_W-1:0] r_old, n_old;
    logic [LW-1:0]       r_slot, n_slot;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [SW-1:0]       r_sum, n_sum;
    logic [QSW-1:0]      r_sumsq, n_sumsq;
    logic [MV_W-1:0]     r_fs;
    logic [DW-1:0]       r_t1, n_t1;
    logic [DW-1:0]       r_d, n_d;
    logic [VW-1:0]       r_den, n_den;
    logic [NW-1:0]       r_q, n_q;
    logic [SIG_W-1:0]    r_sig, n_sig;
    logic [MEAN_W-1:0]   r_mean, n_mean;
    logic [MV_W-1:0]     r_exp, n_exp;
    logic                r_ovalid;
    logic                load_out;
    logic                accept;
    logic                mem_we;

    logic                mul_start, mul_done;
    logic [MA-1:0]       mul_a;
    logic [MB-1:0]       mul_b;
    logic [PW-1:0]       mul_p;
    logic                div_start, div_done;
    logic [NW-1:0]       div_n;
    logic [VW-1:0]       div_d;
    logic [NW-1:0]       div_q;
    logic                sqrt_start, sqrt_done;
    logic [RW-1:0]       sqrt_root;
    logic [RW:0]         rnd;

    assign accept  = i_valid && (r_state == ST_IDLE);
    assign o_stall = (r_state != ST_IDLE);

    mmsd_mul #(.AW(MA), .BW(MB)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    mmsd_div #(.NW(NW), .VW(VW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_n     (div_n),
        .i_d     (div_d),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    mmsd_sqrt #(.RW(RW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_x     ((2*RW)'(r_q)),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= mem[r_slot];
        end
        if (mem_we) begin
            mem[r_slot] <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_run    <= 1'b0;
            r_slot   <= '0;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_sumsq  <= '0;
            r_fs     <= FS_MV_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
            r_slot  <= n_slot;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_sumsq <= n_sumsq;
            if (i_cfg_we) begin
                r_fs <= i_cfg_wdata;
            end
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= i_sample;
        end
        r_old  <= n_old;
        r_t1   <= n_t1;
        r_d    <= n_d;
        r_den  <= n_den;
        r_q    <= n_q;
        r_sig  <= n_sig;
        r_mean <= n_mean;
        r_exp  <= n_exp;
        if (load_out) begin
            o_mean_q4     <= r_mean;
            o_sigma_q4    <= r_sig;
            o_expected_mv <= r_exp;
            o_fill_count  <= CNT_W'(r_cnt);
        end
    end

    assign o_valid = r_ovalid;
    assign rnd     = (RW+1)'(sqrt_root) + 1'b1;

    always_comb begin
        n_state    = r_state;
        n_run      = r_run;
        n_old      = r_old;
        n_slot     = r_slot;
        n_cnt      = r_cnt;
        n_sum      = r_sum;
        n_sumsq    = r_sumsq;
        n_t1       = r_t1;
        n_d        = r_d;
        n_den      = r_den;
        n_q        = r_q;
        n_sig      = r_sig;
        n_mean     = r_mean;
        n_exp      = r_exp;
        load_out   = 1'b0;
        mem_we     = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_n      = '0;
        div_d      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_old  = (r_cnt == CW'(WINDOW)) ? r_rd : '0;
                n_sum  = r_sum - SW'(n_old) + SW'(r_x);
                mem_we = 1'b1;
                n_slot = (r_slot == LW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                if (r_cnt != CW'(WINDOW)) begin
                    n_cnt = r_cnt + 1'b1;
                end
                n_state = ST_SQO;
            end
            ST_SQO: begin
                mul_a = MA'(r_old);
                mul_b = MB'(r_old);
                mul_start = !r_run;
                n_run = 1'b1;
                if (mul_done) begin
                    n_sumsq = r_sumsq - QSW'(mul_p);
                    n_run   = 1'b0;
                    n_state = ST_SQX;
                end
            end
            ST_SQX: begin
                mul_a = MA'(r_x);
                mul_b = MB'(r_x);
                mul_start = !r_run;
                n_run = 1'b1;
                if (mul_done) begin
                    n_sumsq = r_sumsq + QSW'(mul_p);
                    n_run   = 1'b0;
                    n_state = ST_CSQ;
                end
            end
            ST_CSQ: begin
                mul_a = r_sumsq;
                mul_b = MB'(r_cnt);
                mul_start = !r_run;
                n_run = 1'b1;
                if (mul_done) begin
                    n_t1    = DW'(mul_p);
                    n_run   = 1'b0;
                    n_state = ST_SS;
                end
            end
            ST_SS: begin
                mul_a = MA'(r_sum);
                mul_b = MB'(r_sum);
                mul_start = !r_run;
                n_run = 1'b1;
                if (mul_done) begin
                    n_d     = r_t1 - DW'(mul_p);
                    n_run   = 1'b0;
                    n_state = ST_DEN;
                end
            end
            ST_DEN: begin
                mul_a = MA'(r_cnt);
                mul_b = MB'(r_cnt - 1'b1);
                mul_start = !r_run;
                n_run = 1'b1;
                if (mul_done) begin
                    n_den   = VW'(mul_p);
                    n_run   = 1'b0;
                    n_state = ST_DV1;
                end
            end
            ST_DV1: begin
                div_n = {r_d, 10'b0};
                div_d = r_den;
                div_start = !r_run;
                n_run = 1'b1;
                if (div_done) begin
                    n_q     = div_q;
                    n_run   = 1'b0;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                sqrt_start = !r_run;
                n_run = 1'b1;
                if (sqrt_done) begin
                    priority if (r_cnt == CW'(1)) begin
                        n_sig = '0;
                    end else if ((rnd >> 1) > (RW+1)'(SIG_MAX)) begin
                        n_sig = SIG_MAX;
                    end else begin
                        n_sig = SIG_W'(rnd >> 1);
                    end
                    n_run   = 1'b0;
                    n_state = ST_DV2;
                end
            end
            ST_DV2: begin
                div_n = NW'({r_sum, 5'b0}) + NW'(r_cnt);
                div_d = VW'({r_cnt, 1'b0});
                div_start = !r_run;
                n_run = 1'b1;
                if (div_done) begin
                    n_mean  = MEAN_W'(div_q);
                    n_run   = 1'b0;
                    n_state = ST_SFS;
                end
            end
            ST_SFS: begin
                mul_a = MA'(r_sum);
                mul_b = MB'(r_fs);
                mul_start = !r_run;
                n_run = 1'b1;
                if (mul_done) begin
                    n_t1    = DW'(mul_p);
                    n_run   = 1'b0;
                    n_state = ST_FC;
                end
            end
            ST_FC: begin
                mul_a = MA'(ADC_FULL_CODE);
                mul_b = MB'(r_cnt);
                mul_start = !r_run;
                n_run = 1'b1;
                if (mul_done) begin
                    n_den   = VW'(mul_p);
                    n_run   = 1'b0;
                    n_state = ST_DV3;
                end
            end
            ST_DV3: begin
                div_n = NW'(r_t1);
                div_d = r_den;
                div_start = !r_run;
                n_run = 1'b1;
                if (div_done) begin
                    n_exp   = MV_W'(div_q);
                    n_run   = 1'b0;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_run   = 1'b0;
            end
        endcase
    end

    `MMSD_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CW'(WINDOW), "fill count beyond window")
    `MMSD_ASSERT_NEXT(a_accept_rd, accept, r_state == ST_RD, "accepted transaction not read")
    `MMSD_ASSERT_NOW(a_mean_bound, o_valid, o_mean_q4 <= 16'd65520, "mean above full code")
    `MMSD_ASSERT_NOW(a_one_unit, mul_start, !div_start && !sqrt_start, "two units started")
endmodule

FILE: hdl/mmsd_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
// Standalone; used by the top level.
module mmsd_mul #(
    parameter int AW = 32,
    parameter int BW = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [AW-1:0]  i_a,
    input  logic [BW-1:0]  i_b,
    output logic           o_done,
    output logic [AW+BW-1:0] o_prod
);
    localparam int PW = AW + BW;
    localparam int KW = $clog2(BW + 1);

    logic [PW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [PW-1:0] r_acc;
    logic [KW-1:0] r_k;
    logic          r_busy;
    logic          r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= PW'(i_a);
                r_b    <= i_b;
                r_acc  <= '0;
                r_k    <= KW'(BW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= r_a << 1;
                r_b <= r_b >> 1;
                r_k <= r_k - 1'b1;
                if (r_k == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

FILE: hdl/mmsd_div.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the top level.
module mmsd_div #(
    parameter int NW = 48,
    parameter int VW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_n,
    input  logic [VW-1:0] i_d,
    output logic          o_done,
    output logic [NW-1:0] o_q
);
    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] r_n;
    logic [NW-1:0] r_q;
    logic [VW-1:0] r_d;
    logic [VW-1:0] r_rem;
    logic [KW-1:0] r_k;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   trial;
    logic          ge;

    assign trial = {r_rem, r_n[NW-1]};
    assign ge    = (trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n    <= i_n;
                r_d    <= i_d;
                r_q    <= '0;
                r_rem  <= '0;
                r_k    <= KW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? VW'(trial - {1'b0, r_d}) : VW'(trial);
                r_q   <= {r_q[NW-2:0], ge};
                r_n   <= r_n << 1;
                r_k   <= r_k - 1'b1;
                if (r_k == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

FILE: hdl/mmsd_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Standalone; used by the top level.
module mmsd_sqrt #(
    parameter int RW = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2*RW-1:0] i_x,
    output logic            o_done,
    output logic [RW-1:0]   o_root
);
    localparam int KW = $clog2(RW + 1);

    logic [2*RW-1:0] r_x;
    logic [RW-1:0]   r_root;
    logic [RW-1:0]   r_rem;
    logic [KW-1:0]   r_k;
    logic            r_busy;
    logic            r_done;
    logic [RW+1:0]   t;
    logic [RW+1:0]   trial;
    logic            ge;

    assign t     = {r_rem, r_x[2*RW-1 -: 2]};
    assign trial = {r_root, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_root <= '0;
                r_rem  <= '0;
                r_k    <= KW'(RW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= ge ? RW'(t - trial) : RW'(t);
                r_root <= {r_root[RW-2:0], ge};
                r_x    <= r_x << 2;
                r_k    <= r_k - 1'b1;
                if (r_k == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
